>>> rtl/rpot_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpot_pkg
// shared types and constants for the first-write range paint segment tree
// ----------------------------------------------------------------------------
package rpot_pkg;

	localparam int FIELD_W = 11;
	localparam int MARK_W = 11;
	localparam int POS_W = FIELD_W + 1;
	localparam int MAX_POSITIONS_DEF = 1024;
	localparam logic [FIELD_W-1:0] POSITION_COUNT_RST = 11'd1024;

	typedef enum logic [0:0] {
		MODE_PAINT = 1'b0,
		MODE_READ  = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_WALK,
		ST_REPLY
	} state_t;

	typedef struct packed {
		mode_t              mode;
		logic [FIELD_W-1:0] first_position;
		logic [FIELD_W-1:0] last_position;
		logic [FIELD_W-1:0] winner;
		logic [FIELD_W-1:0] read_position;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] position_mark;
		logic [FIELD_W-1:0] echo_position;
	} rsp_t;

	// token walking down the level chain
	typedef struct packed {
		logic              vld;
		logic              is_read;
		logic              live;
		logic              reach_a;
		logic              reach_b;
		logic [MARK_W-1:0] mark;
		logic [MARK_W-1:0] val;
	} tok_t;

endpackage
`default_nettype wire

>>> rtl/range_paint_once_tree_core.sv
// a read is loaded into the level cells, walked through them as a token, then registered as the result
// a paint walks each of its up to two ranges, split around the winner, in turn
// one item at a time: the input stalls while an item walks the LG+1 level cells or waits to reply
// reset: marks are cleared by a pass over the cell rows, input stalled meanwhile
`default_nettype none
// ----------------------------------------------------------------------------
// range_paint_once_tree_core
// first-write range paint and point read over a level-per-cell segment tree
// ----------------------------------------------------------------------------
module range_paint_once_tree_core #(
	parameter int MAX_POSITIONS = rpot_pkg::MAX_POSITIONS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire rpot_pkg::req_t                req,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output rpot_pkg::rsp_t                     rsp,
	input  wire logic                          cfg_we,
	input  wire logic [rpot_pkg::FIELD_W-1:0]  cfg_wdata
);

	localparam int LG = $clog2(MAX_POSITIONS);
	localparam int LEVELS = LG + 1;
	localparam int PW = rpot_pkg::POS_W;
	localparam int FW = rpot_pkg::FIELD_W;
	localparam logic [LG-1:0] CLR_LAST = LG'((2 ** (LG - 1)) - 1);

	rpot_pkg::state_t state_q;
	rpot_pkg::state_t state_d;

	logic [LG-1:0] clr_q;
	logic [FW-1:0] pc_q;
	logic          go_q;
	logic          pend_vld_q;
	logic          rsp_vld_q;
	logic [LG-1:0] cur_a_q;
	logic [LG-1:0] cur_b_q;
	logic [LG-1:0] pend_a_q;
	logic [LG-1:0] pend_b_q;
	logic          cur_read_q;
	logic          cur_live_q;
	logic [FW-1:0] mark_q;
	logic [FW-1:0] echo_q;
	logic [FW-1:0] res_q;
	rpot_pkg::rsp_t rsp_q;

	logic [PW-1:0] n;
	logic [PW-1:0] f;
	logic [PW-1:0] l;
	logic [PW-1:0] w;
	logic [PW-1:0] p;
	logic [PW-1:0] wm1;
	logic [PW-1:0] wp1;
	logic          paint_ok;
	logic          r1_vld;
	logic          r2_vld;
	logic [PW-1:0] r1_b;
	logic [PW-1:0] r2_a;
	logic          live;
	logic          is_read;
	logic          accept;
	logic          out_vld;
	logic          rsp_load;

	rpot_pkg::tok_t tok_c [LEVELS+1];

	// operand clipping and split around the winner
	always_comb begin
		if (pc_q == '0) begin
			n = PW'(1);
		end else if (32'(pc_q) > 32'(MAX_POSITIONS)) begin
			n = PW'(MAX_POSITIONS);
		end else begin
			n = {1'b0, pc_q};
		end
		f = {1'b0, req.first_position};
		if (f == '0) begin
			f = PW'(1);
		end
		l = {1'b0, req.last_position};
		if (l > n) begin
			l = n;
		end
		w = {1'b0, req.winner};
		p = {1'b0, req.read_position};
		wm1 = w - PW'(1);
		wp1 = w + PW'(1);
		paint_ok = (w != '0) && (f <= l);
		r1_vld = paint_ok && (wm1 >= f);
		r2_vld = paint_ok && (wp1 <= l);
		r1_b = (wm1 < l) ? wm1 : l;
		r2_a = (wp1 > f) ? wp1 : f;
		live = (p != '0) && (p <= n);
		is_read = (req.mode == rpot_pkg::MODE_READ);
	end

	assign accept = (state_q == rpot_pkg::ST_IDLE) && req_valid;
	assign out_vld = tok_c[LEVELS].vld;
	assign rsp_load = (state_q == rpot_pkg::ST_REPLY) && (!rsp_vld_q || !rsp_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpot_pkg::ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = rpot_pkg::ST_IDLE;
				end
			end
			rpot_pkg::ST_IDLE: begin
				if (req_valid && (is_read || r1_vld || r2_vld)) begin
					state_d = rpot_pkg::ST_LOAD;
				end
			end
			rpot_pkg::ST_LOAD: begin
				state_d = rpot_pkg::ST_WALK;
			end
			rpot_pkg::ST_WALK: begin
				if (out_vld) begin
					if (cur_read_q) begin
						state_d = rpot_pkg::ST_REPLY;
					end else if (pend_vld_q) begin
						state_d = rpot_pkg::ST_LOAD;
					end else begin
						state_d = rpot_pkg::ST_IDLE;
					end
				end
			end
			rpot_pkg::ST_REPLY: begin
				if (!rsp_vld_q || !rsp_stall) begin
					state_d = rpot_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rpot_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpot_pkg::ST_CLEAR;
			clr_q <= '0;
			pc_q <= rpot_pkg::POSITION_COUNT_RST;
			go_q <= 1'b0;
			pend_vld_q <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rpot_pkg::ST_CLEAR) begin
				clr_q <= clr_q + LG'(1);
			end
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end
			go_q <= (state_q == rpot_pkg::ST_LOAD);
			if (accept) begin
				pend_vld_q <= !is_read && r1_vld && r2_vld;
			end else if ((state_q == rpot_pkg::ST_WALK) && out_vld) begin
				pend_vld_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_vld_q && !rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_read_q <= is_read;
			cur_live_q <= live;
			mark_q <= req.winner;
			echo_q <= req.read_position;
			pend_a_q <= LG'(r2_a - PW'(1));
			pend_b_q <= LG'(l - PW'(1));
			if (is_read) begin
				cur_a_q <= LG'(p - PW'(1));
				cur_b_q <= LG'(p - PW'(1));
			end else if (r1_vld) begin
				cur_a_q <= LG'(f - PW'(1));
				cur_b_q <= LG'(r1_b - PW'(1));
			end else begin
				cur_a_q <= LG'(r2_a - PW'(1));
				cur_b_q <= LG'(l - PW'(1));
			end
		end else if ((state_q == rpot_pkg::ST_WALK) && out_vld) begin
			res_q <= tok_c[LEVELS].val;
			if (pend_vld_q) begin
				cur_a_q <= pend_a_q;
				cur_b_q <= pend_b_q;
			end
		end
		if (rsp_load) begin
			rsp_q.position_mark <= res_q;
			rsp_q.echo_position <= echo_q;
		end
	end

	always_comb begin
		tok_c[0].vld = go_q;
		tok_c[0].is_read = cur_read_q;
		tok_c[0].live = cur_live_q;
		tok_c[0].reach_a = 1'b1;
		tok_c[0].reach_b = 1'b1;
		tok_c[0].mark = mark_q;
		tok_c[0].val = '0;
	end

	for (genvar d = 0; d < LEVELS; d++) begin : g_level
		rpot_cell #(
			.LEVEL  (d),
			.LEAF_W (LG)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rd_en   (state_q == rpot_pkg::ST_LOAD),
			.a0      (cur_a_q),
			.b0      (cur_b_q),
			.clr_en  (state_q == rpot_pkg::ST_CLEAR),
			.clr_row (clr_q),
			.tok_in  (tok_c[d]),
			.tok_out (tok_c[d+1])
		);
	end

	assign req_stall = (state_q != rpot_pkg::ST_IDLE);
	assign rsp_valid = rsp_vld_q;
	assign rsp = rsp_q;

endmodule
`default_nettype wire

>>> rtl/rpot_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpot_cell
// one tree level: node marks stored as sibling pairs, boundary path update
// ----------------------------------------------------------------------------
module rpot_cell #(
	parameter int LEVEL  = 0,
	parameter int LEAF_W = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_en,
	input  wire logic [LEAF_W-1:0]   a0,
	input  wire logic [LEAF_W-1:0]   b0,
	input  wire logic                clr_en,
	input  wire logic [LEAF_W-1:0]   clr_row,
	input  wire rpot_pkg::tok_t      tok_in,
	output rpot_pkg::tok_t           tok_out
);

	localparam int MW = rpot_pkg::MARK_W;
	localparam int RW = (LEVEL > 1) ? LEVEL - 1 : 1;
	localparam int ROWS = 2 ** RW;
	localparam int SHIFT = LEAF_W - LEVEL;
	localparam logic [LEAF_W-1:0] LOW_MASK = {LEAF_W{1'b1}} >> LEVEL;
	localparam logic [LEAF_W-1:0] ONE = LEAF_W'(1);

	logic [2*MW-1:0] mem [ROWS];
	logic [2*MW-1:0] rd_a_q;
	logic [2*MW-1:0] rd_b_q;

	logic [LEAF_W-1:0] idx_a;
	logic [LEAF_W-1:0] idx_b;
	logic [RW-1:0]     row_a;
	logic [RW-1:0]     row_b;
	logic              h_a;
	logic              h_b;
	logic [MW-1:0]     mark_na;
	logic [MW-1:0]     mark_nb;
	logic              full_a;
	logic              full_b;
	logic              paint;
	logic              set_na;
	logic              set_sa;
	logic              set_nb;
	logic              set_sb;
	logic              same_row;
	logic              a_lo;
	logic              a_hi;
	logic              b_lo;
	logic              b_hi;
	logic [2*MW-1:0]   new_a;
	logic [2*MW-1:0]   new_b;

	logic              wr_en;
	logic [RW-1:0]     wr_row;
	logic [2*MW-1:0]   wr_data;

	logic              pend_vld_q;
	logic [RW-1:0]     pend_row_q;
	logic [2*MW-1:0]   pend_data_q;
	rpot_pkg::tok_t    tok_q;
	rpot_pkg::tok_t    tok_d;

	// node geometry at this level
	assign idx_a = a0 >> SHIFT;
	assign idx_b = b0 >> SHIFT;
	assign row_a = RW'(idx_a >> 1);
	assign row_b = RW'(idx_b >> 1);
	assign h_a = idx_a[0];
	assign h_b = idx_b[0];
	assign same_row = (row_a == row_b);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem[row_a];
			rd_b_q <= mem[row_b];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
	end

	always_comb begin
		mark_na = h_a ? rd_a_q[2*MW-1:MW] : rd_a_q[MW-1:0];
		mark_nb = h_b ? rd_b_q[2*MW-1:MW] : rd_b_q[MW-1:0];
		full_a = ((a0 & LOW_MASK) == '0) && ((a0 | LOW_MASK) <= b0);
		full_b = ((b0 & LOW_MASK) == LOW_MASK) && ((b0 & ~LOW_MASK) >= a0);
		paint = tok_in.vld && !tok_in.is_read;

		set_na = paint && tok_in.reach_a && (mark_na == '0) && full_a;
		set_sa = paint && tok_in.reach_a && !h_a && (idx_b > (idx_a | ONE)) &&
			(rd_a_q[2*MW-1:MW] == '0);
		set_nb = paint && tok_in.reach_b && (mark_nb == '0) && full_b;
		set_sb = paint && tok_in.reach_b && h_b && (idx_a < (idx_b & ~ONE)) &&
			(rd_b_q[MW-1:0] == '0);

		a_lo = (!h_a && set_na) || (same_row && ((!h_b && set_nb) || set_sb));
		a_hi = (h_a && set_na) || set_sa || (same_row && h_b && set_nb);
		b_lo = !same_row && ((!h_b && set_nb) || set_sb);
		b_hi = !same_row && h_b && set_nb;

		new_a = {a_hi ? tok_in.mark : rd_a_q[2*MW-1:MW],
			a_lo ? tok_in.mark : rd_a_q[MW-1:0]};
		new_b = {b_hi ? tok_in.mark : rd_b_q[2*MW-1:MW],
			b_lo ? tok_in.mark : rd_b_q[MW-1:0]};

		tok_d = tok_in;
		tok_d.reach_a = tok_in.reach_a && (mark_na == '0) && !full_a;
		tok_d.reach_b = tok_in.reach_b && (mark_nb == '0) && !full_b;
		if (tok_in.vld && tok_in.is_read && tok_in.live && (mark_na != '0)) begin
			tok_d.val = mark_na;
		end
	end

	// single write port: clearing pass, boundary row a, then deferred row b
	always_comb begin
		wr_en = 1'b0;
		wr_row = row_a;
		wr_data = new_a;
		if (clr_en) begin
			wr_en = 1'b1;
			wr_row = RW'(clr_row);
			wr_data = '0;
		end else if (a_lo || a_hi) begin
			wr_en = 1'b1;
		end else if (pend_vld_q) begin
			wr_en = 1'b1;
			wr_row = pend_row_q;
			wr_data = pend_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			tok_q <= '0;
		end else begin
			pend_vld_q <= b_lo || b_hi;
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_row_q <= row_b;
		pend_data_q <= new_b;
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

>>> test/tb_range_paint_once_tree_core.sv
// ----------------------------------------------------------------------------
// tb_range_paint_once_tree_core
// Drives paint and read transactions into the first-write range paint tree.
// A flat per-position owner table predicts every read: a position keeps the
// first winner whose range covered it. The position count register is moved
// through its extremes between traffic phases, both handshakes idle and stall
// at random, and a checker compares each result with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_range_paint_once_tree_core;

	localparam int FW = rpot_pkg::FIELD_W;
	localparam int MAXP = rpot_pkg::MAX_POSITIONS_DEF;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int FIELD_MAX = (1 << FW) - 1;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	rpot_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rpot_pkg::rsp_t rsp;
	logic cfg_we;
	logic [FW-1:0] cfg_wdata;

	// predicted state
	logic [rpot_pkg::MARK_W-1:0] first_owner [1:MAXP];
	logic [FW-1:0] count_reg;
	rpot_pkg::rsp_t pending_marks [$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_ticket;
	int cycle_count;
	int mismatch_count;
	int reads_checked;
	int paints_applied;
	int cfg_writes;

	range_paint_once_tree_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_marks.size());
		$display("tb_range_paint_once_tree_core failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < 40) begin
			$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what,
				got, want);
		end
		mismatch_count++;
	endtask

	function automatic int used_count();
		int n;
		n = int'(count_reg);
		if (n < 1) n = 1;
		if (n > MAXP) n = MAXP;
		return n;
	endfunction

	task automatic apply_to_owners(input rpot_pkg::req_t t);
		int n;
		int lo;
		int hi;
		int w;
		int p;
		rpot_pkg::rsp_t want;
		n = used_count();
		if (t.mode == rpot_pkg::MODE_PAINT) begin
			w = int'(t.winner);
			lo = int'(t.first_position);
			hi = int'(t.last_position);
			if (lo < 1) lo = 1;
			if (hi > n) hi = n;
			if (w != 0) begin
				for (p = lo; p <= hi; p++) begin
					if (p != w && first_owner[p] == '0) first_owner[p] = t.winner;
				end
			end
			paints_applied++;
		end else begin
			p = int'(t.read_position);
			want.position_mark = (p >= 1 && p <= n) ? first_owner[p] : '0;
			want.echo_position = t.read_position;
			pending_marks.push_back(want);
		end
	endtask

	task automatic check_result(input rpot_pkg::rsp_t got);
		rpot_pkg::rsp_t want;
		if (pending_marks.size() == 0) begin
			report_mismatch("unexpected result, mark", int'(got.position_mark), 0);
			return;
		end
		want = pending_marks.pop_front();
		if (got.position_mark !== want.position_mark)
			report_mismatch("position_mark", int'(got.position_mark),
				int'(want.position_mark));
		if (got.echo_position !== want.echo_position)
			report_mismatch("echo_position", int'(got.echo_position),
				int'(want.echo_position));
		reads_checked++;
	endtask

	// result side: random stall, long hold on request, check each result
	initial begin
		int hold_left;
		int served;
		hold_left = 0;
		served = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) check_result(rsp);
			if (served != hold_ticket) begin
				served = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	task automatic send_item(input rpot_pkg::req_t t);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= t;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		apply_to_owners(t);
	endtask

	task automatic wait_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_marks.size() != 0);
	endtask

	task automatic set_position_count(input logic [FW-1:0] value);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_reg = value;
		cfg_writes++;
	endtask

	function automatic rpot_pkg::req_t paint_item(input int f, input int l, input int w);
		rpot_pkg::req_t t;
		t.mode = rpot_pkg::MODE_PAINT;
		t.first_position = FW'(f);
		t.last_position = FW'(l);
		t.winner = FW'(w);
		t.read_position = FW'($urandom_range(0, FIELD_MAX));
		return t;
	endfunction

	function automatic rpot_pkg::req_t read_item(input int p);
		rpot_pkg::req_t t;
		t.mode = rpot_pkg::MODE_READ;
		t.first_position = FW'($urandom_range(0, FIELD_MAX));
		t.last_position = FW'($urandom_range(0, FIELD_MAX));
		t.winner = FW'($urandom_range(0, FIELD_MAX));
		t.read_position = FW'(p);
		return t;
	endfunction

	function automatic rpot_pkg::req_t random_item();
		rpot_pkg::req_t t;
		int n;
		int r;
		int base;
		int last;
		int w;
		n = used_count();
		r = $urandom_range(0, 99);
		if (r < 8) begin
			t.mode = rpot_pkg::mode_t'($urandom_range(0, 1));
			t.first_position = FW'($urandom_range(0, FIELD_MAX));
			t.last_position = FW'($urandom_range(0, FIELD_MAX));
			t.winner = FW'($urandom_range(0, FIELD_MAX));
			t.read_position = FW'($urandom_range(0, FIELD_MAX));
		end else if (r < 50) begin
			if ($urandom_range(0, 9) == 0) t = read_item($urandom_range(0, FIELD_MAX));
			else t = read_item($urandom_range(1, n));
		end else begin
			base = $urandom_range(1, n);
			if ($urandom_range(0, 63) == 0) last = base + $urandom_range(0, n / 4);
			else last = base + $urandom_range(0, 5);
			if (last > FIELD_MAX) last = FIELD_MAX;
			case ($urandom_range(0, 9))
				0: w = 0;
				1, 2: w = $urandom_range(1, FIELD_MAX);
				3, 4: w = $urandom_range(1, n);
				default: w = $urandom_range(base, last);
			endcase
			t = paint_item(base, last, w);
		end
		return t;
	endfunction

	function automatic logic [FW-1:0] pick_count();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return FW'(1);
			2: return FW'(2);
			3: return FW'(MAXP);
			4: return FW'(FIELD_MAX);
			5: return FW'($urandom_range(MAXP + 1, FIELD_MAX));
			default: return FW'($urandom_range(3, MAXP - 1));
		endcase
	endfunction

	// unset reads, ignored paints, clipping, winner exclusion, first paint wins
	task automatic test_first_paint_wins();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_item(read_item(1));
		send_item(read_item(MAXP));
		send_item(read_item(0));
		send_item(read_item(FIELD_MAX));
		send_item(paint_item(3, 9, 0));
		send_item(read_item(5));
		send_item(paint_item(9, 3, 4));
		send_item(read_item(4));
		send_item(paint_item(0, 3, 2));
		send_item(read_item(1));
		send_item(read_item(2));
		send_item(read_item(3));
		send_item(paint_item(1000, FIELD_MAX, 1500));
		send_item(read_item(MAXP));
		send_item(read_item(999));
		send_item(paint_item(500, 500, 500));
		send_item(read_item(500));
		send_item(paint_item(10, 20, 15));
		send_item(paint_item(5, 25, 7));
		send_item(read_item(10));
		send_item(read_item(15));
		send_item(read_item(7));
		send_item(read_item(5));
		send_item(read_item(25));
		send_item(read_item(20));
	endtask

	// position count of zero, above the maximum, two and the maximum
	task automatic test_count_limits();
		set_position_count('0);
		send_item(read_item(1));
		send_item(read_item(2));
		send_item(paint_item(1, MAXP, 3));
		set_position_count(FW'(FIELD_MAX));
		send_item(read_item(2));
		send_item(read_item(MAXP));
		set_position_count(FW'(2));
		send_item(paint_item(1, FIELD_MAX, 9));
		send_item(read_item(2));
		send_item(read_item(3));
		set_position_count(FW'(MAXP));
	endtask

	task automatic test_random_traffic(input int items, input int s_pct, input int r_pct);
		int i;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (i = 0; i < items; i++) begin
			if (i > 0 && i % 140 == 0) set_position_count(pick_count());
			else if (i % 97 == 50) wait_results();
			send_item(random_item());
		end
	endtask

	// receiver holds off while reads keep coming, so the input backs up
	task automatic test_result_backpressure();
		int i;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		wait_results();
		hold_ticket <= hold_ticket + 1;
		for (i = 0; i < 24; i++) begin
			if (i % 3 == 0) send_item(random_item());
			else send_item(read_item($urandom_range(1, used_count())));
		end
	endtask

	task automatic test_sender_pause();
		int i;
		send_idle_pct = 10;
		recv_idle_pct = 30;
		for (i = 0; i < 20; i++) begin
			if (i == 10) wait_results();
			send_item(random_item());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		count_reg = rpot_pkg::POSITION_COUNT_RST;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_ticket = 0;
		cycle_count = 0;
		mismatch_count = 0;
		reads_checked = 0;
		paints_applied = 0;
		cfg_writes = 0;
		foreach (first_owner[p]) first_owner[p] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_paint_wins();
		test_count_limits();
		test_random_traffic(560, 21, 46);
		test_random_traffic(560, 46, 21);
		test_result_backpressure();
		test_sender_pause();
		test_random_traffic(560, 0, 0);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_marks.size() != 0)
			report_mismatch("results never returned", 0, pending_marks.size());
		$display("%0d paint and %0d read transactions checked",
			paints_applied, reads_checked);
		$display("across %0d position count writes, idle and stall mixes both ways,",
			cfg_writes);
		$display("a long result hold and a drain pause");
		if (mismatch_count == 0) begin
			$display("tb_range_paint_once_tree_core passed");
		end else begin
			$display("tb_range_paint_once_tree_core failed");
		end
		$finish;
	end

endmodule
